// File: design/tel_pkg.sv
// ----------------------------------------------------------------------------
// tel_pkg - shared constants and types for the template expression lexer
// Holds the token and bundle formats passed between the scanner, the result
// queue and the output stage.
// ----------------------------------------------------------------------------
package tel_pkg;

    localparam int MAX_TEXT_LEN = 65535;
    localparam int POS_W        = $clog2(MAX_TEXT_LEN + 1);

    // Results one character can cause, and the width of a count of them
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    // Result queue between scanner and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Token kinds
    localparam logic [3:0] KIND_PIPE     = 4'd0;
    localparam logic [3:0] KIND_COLON    = 4'd1;
    localparam logic [3:0] KIND_DOT      = 4'd2;
    localparam logic [3:0] KIND_COMMA    = 4'd3;
    localparam logic [3:0] KIND_LBRACKET = 4'd4;
    localparam logic [3:0] KIND_RBRACKET = 4'd5;
    localparam logic [3:0] KIND_INT      = 4'd6;
    localparam logic [3:0] KIND_STRING   = 4'd7;
    localparam logic [3:0] KIND_IDENT    = 4'd8;
    localparam logic [3:0] KIND_BOOL     = 4'd9;
    localparam logic [3:0] KIND_OPER     = 4'd10;
    localparam logic [3:0] KIND_END      = 4'd11;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
    localparam logic [1:0] ERR_UNTERM   = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [1:0]  err;
    } token_t;

    // All results caused by one character, oldest in tok[0]
    typedef struct packed {
        logic [CNT_W-1:0]         count;
        token_t [MAX_RES-1:0]     tok;
    } bundle_t;

endpackage

// File: design/tel_front.sv
// ----------------------------------------------------------------------------
// tel_front - character scanner
// Classifies one character per cycle, while accept is high, against the
// running scan state and gathers the tokens it completes into one bundle.
// ----------------------------------------------------------------------------
module tel_front
    import tel_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] character,
    input  logic       text_end,
    input  logic       accept,
    output bundle_t    bundle,
    output logic       bundle_valid
);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_IDENT   = 3'd1;
    localparam logic [2:0] MODE_INT     = 3'd2;
    localparam logic [2:0] MODE_STR     = 3'd3;
    localparam logic [2:0] MODE_OP      = 3'd4;
    localparam logic [2:0] MODE_DISCARD = 3'd5;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_LESS = 2'd1;
    localparam logic [1:0] OP_GREQ = 2'd2;
    localparam logic [1:0] OP_BANG = 2'd3;

    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;

    localparam int NUM_SLOTS = 4;

    logic [2:0]       mode_reg, mode_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             dq_reg, dq_next;
    logic [3:0]       kw_reg, kw_next;
    logic [1:0]       pend_reg, pend_next;

    token_t [NUM_SLOTS-1:0] slot;
    logic   [NUM_SLOTS-1:0] slot_v;
    logic                   do_start;
    logic                   at_limit;
    logic                   ident_char;
    logic [CNT_W-1:0]       cnt;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    // Keyword tracker: first letters of or, and, true, false
    function automatic logic [3:0] kw_first(input logic [7:0] c);
        logic [3:0] s;
        unique case (c)
            8'h6F:   s = 4'd1;
            8'h61:   s = 4'd3;
            8'h74:   s = 4'd6;
            8'h66:   s = 4'd10;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // Letter needed to advance from each tracker state; zero ends a word
    function automatic logic [7:0] kw_need(input logic [3:0] s);
        logic [7:0] c;
        unique case (s)
            4'd1:    c = 8'h72;
            4'd3:    c = 8'h6E;
            4'd4:    c = 8'h64;
            4'd6:    c = 8'h72;
            4'd7:    c = 8'h75;
            4'd8:    c = 8'h65;
            4'd10:   c = 8'h61;
            4'd11:   c = 8'h6C;
            4'd12:   c = 8'h73;
            4'd13:   c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic token_t make_tok(input logic [3:0] kind, input logic [POS_W-1:0] start,
                                        input logic [POS_W-1:0] len, input logic [1:0] err);
        token_t t;
        t.kind  = kind;
        t.start = 16'(start);
        t.len   = 16'(len);
        t.err   = err;
        return t;
    endfunction

    function automatic logic flushable(input logic [2:0] mode);
        return mode == MODE_IDENT || mode == MODE_INT || mode == MODE_OP;
    endfunction

    // Token left pending by an identifier, integer or operator
    function automatic token_t flush_tok(input logic [2:0] mode, input logic [POS_W-1:0] start,
                                         input logic [3:0] kw, input logic [POS_W-1:0] endpos);
        token_t     t;
        logic [3:0] k;
        if (kw == 4'd2 || kw == 4'd5)
            k = KIND_OPER;
        else if (kw == 4'd9 || kw == 4'd14)
            k = KIND_BOOL;
        else
            k = KIND_IDENT;
        if (mode == MODE_OP)
            t = make_tok(KIND_OPER, start, POS_W'(1), ERR_NONE);
        else if (mode == MODE_INT)
            t = make_tok(KIND_INT, start, endpos - start, ERR_NONE);
        else
            t = make_tok(k, start, endpos - start, ERR_NONE);
        return t;
    endfunction

    assign at_limit   = pos_reg >= POS_W'(MAX_TEXT_LEN);
    assign ident_char = is_letter(character) || is_digit(character) || character == CH_UNDER;

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        dq_next    = dq_reg;
        kw_next    = kw_reg;
        pend_next  = pend_reg;
        slot       = '0;
        slot_v     = '0;
        do_start   = 1'b0;

        // First phase: the character itself
        if (mode_reg != MODE_DISCARD) begin
            if (at_limit) begin
                slot_v[0]  = flushable(mode_reg);
                slot[0]    = flush_tok(mode_reg, start_reg, kw_reg, pos_reg);
                slot_v[1]  = 1'b1;
                slot[1]    = make_tok(KIND_END, pos_reg, '0, ERR_TOO_LONG);
                mode_next  = MODE_DISCARD;
                pend_next  = OP_NONE;
                kw_next    = '0;
            end else begin
                unique case (mode_reg)
                    MODE_IDENT:
                    begin
                        if (ident_char) begin
                            if (kw_need(kw_reg) != 8'h00 && character == kw_need(kw_reg))
                                kw_next = kw_reg + 4'd1;
                            else
                                kw_next = '0;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                    MODE_INT:
                    begin
                        if (!is_digit(character))
                            do_start = 1'b1;
                    end
                    MODE_STR:
                    begin
                        if (character == (dq_reg ? CH_DQUOTE : CH_SQUOTE)) begin
                            slot_v[1] = 1'b1;
                            slot[1]   = make_tok(KIND_STRING, start_reg,
                                                 pos_reg - start_reg + POS_W'(1), ERR_NONE);
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_OP:
                    begin
                        if (character == CH_EQUAL || (pend_reg == OP_LESS && character == CH_GREAT))
                        begin
                            slot_v[1] = 1'b1;
                            slot[1]   = make_tok(KIND_OPER, start_reg, POS_W'(2), ERR_NONE);
                            mode_next = MODE_IDLE;
                            pend_next = OP_NONE;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                    MODE_DISCARD:
                    begin
                    end
                    default:
                    begin
                        do_start = 1'b1;
                    end
                endcase

                if (do_start) begin
                    // Close whatever token is pending, then start on this character
                    slot_v[0] = flushable(mode_reg);
                    slot[0]   = flush_tok(mode_reg, start_reg, kw_reg, pos_reg);
                    mode_next = MODE_IDLE;
                    if (flushable(mode_reg)) begin
                        pend_next = OP_NONE;
                        kw_next   = '0;
                    end

                    unique case (character)
                        CH_PIPE:
                        begin
                            slot_v[1] = 1'b1;
                            slot[1]   = make_tok(KIND_PIPE, pos_reg, POS_W'(1), ERR_NONE);
                        end
                        CH_COLON:
                        begin
                            slot_v[1] = 1'b1;
                            slot[1]   = make_tok(KIND_COLON, pos_reg, POS_W'(1), ERR_NONE);
                        end
                        CH_DOT:
                        begin
                            slot_v[1] = 1'b1;
                            slot[1]   = make_tok(KIND_DOT, pos_reg, POS_W'(1), ERR_NONE);
                        end
                        CH_COMMA:
                        begin
                            slot_v[1] = 1'b1;
                            slot[1]   = make_tok(KIND_COMMA, pos_reg, POS_W'(1), ERR_NONE);
                        end
                        CH_LBRK:
                        begin
                            slot_v[1] = 1'b1;
                            slot[1]   = make_tok(KIND_LBRACKET, pos_reg, POS_W'(1), ERR_NONE);
                        end
                        CH_RBRK:
                        begin
                            slot_v[1] = 1'b1;
                            slot[1]   = make_tok(KIND_RBRACKET, pos_reg, POS_W'(1), ERR_NONE);
                        end
                        CH_SQUOTE, CH_DQUOTE:
                        begin
                            mode_next  = MODE_STR;
                            start_next = pos_reg;
                            dq_next    = character == CH_DQUOTE;
                        end
                        CH_LESS, CH_GREAT, CH_EQUAL, CH_BANG:
                        begin
                            mode_next  = MODE_OP;
                            start_next = pos_reg;
                            pend_next  = (character == CH_LESS) ? OP_LESS :
                                         (character == CH_BANG) ? OP_BANG : OP_GREQ;
                        end
                        default:
                        begin
                            if (is_blank(character)) begin
                                mode_next = MODE_IDLE;
                            end else if (is_digit(character)) begin
                                mode_next  = MODE_INT;
                                start_next = pos_reg;
                            end else if (is_letter(character) || character == CH_UNDER) begin
                                mode_next  = MODE_IDENT;
                                start_next = pos_reg;
                                kw_next    = kw_first(character);
                            end else begin
                                slot_v[1] = 1'b1;
                                slot[1]   = make_tok(KIND_END, pos_reg, '0, ERR_BAD_CHAR);
                                mode_next = MODE_DISCARD;
                            end
                        end
                    endcase
                end
            end
        end

        if (!at_limit)
            pos_next = pos_reg + POS_W'(1);

        // Second phase: close the text
        if (text_end) begin
            if (mode_next == MODE_STR) begin
                slot_v[2] = 1'b1;
                slot[2]   = make_tok(KIND_END, start_next, '0, ERR_UNTERM);
            end else begin
                slot_v[2] = flushable(mode_next);
                slot[2]   = flush_tok(mode_next, start_next, kw_next, pos_next);
            end
            slot_v[3]  = 1'b1;
            slot[3]    = make_tok(KIND_END, pos_next, '0, ERR_NONE);
            mode_next  = MODE_IDLE;
            start_next = '0;
            pos_next   = '0;
            dq_next    = 1'b0;
            kw_next    = '0;
            pend_next  = OP_NONE;
        end
    end

    // Pack the valid slots, oldest first
    always_comb
    begin
        cnt        = '0;
        bundle.tok = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_v[i] && cnt < CNT_W'(MAX_RES)) begin
                bundle.tok[cnt] = slot[i];
                cnt             = cnt + CNT_W'(1);
            end
        end
        bundle.count = cnt;
        bundle_valid = cnt != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            dq_reg    <= 1'b0;
            kw_reg    <= '0;
            pend_reg  <= OP_NONE;
        end else if (accept) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            dq_reg    <= dq_next;
            kw_reg    <= kw_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// File: design/tel_queue.sv
// ----------------------------------------------------------------------------
// tel_queue - result bundle queue
// Short first-in first-out store of bundles between scanner and output stage.
// ----------------------------------------------------------------------------
module tel_queue
    import tel_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  bundle_t wr_data,
    input  logic    rd_en,
    output bundle_t head,
    output logic    full,
    output logic    empty
);

    bundle_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - (QPTR_W + 1)'(1);
        end
    end

endmodule

// File: design/tel_back.sv
// ----------------------------------------------------------------------------
// tel_back - result issue stage
// Walks through the tokens of the head bundle, one per transaction.
// ----------------------------------------------------------------------------
module tel_back
    import tel_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  bundle_t head,
    input  logic    head_empty,
    input  logic    pop,
    output token_t  cur,
    output logic    cur_last,
    output logic    head_pop
);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             take;

    assign cur      = head.tok[idx_reg];
    assign cur_last = idx_reg == CNT_W'(head.count - CNT_W'(1));
    assign take     = pop && !head_empty;
    assign head_pop = take && cur_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = cur_last ? '0 : idx_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

// File: design/template_expression_lexer.sv
// ----------------------------------------------------------------------------
// template_expression_lexer - streaming lexer for template expressions
// Throughput: one character per cycle while the queue is not full; results leave
// at one per cycle while pop is high; a character yields at most three results.
// Buffering: a four-bundle queue between the scanner and the output stage.
// Reset: rst_n clears scan state and queue pointers at once; no clearing pass.
// ----------------------------------------------------------------------------
module template_expression_lexer
    import tel_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // character side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  character,
    input  logic        text_end,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  kind,
    output logic [15:0] start_res,
    output logic [15:0] length,
    output logic [1:0]  error_code,
    output logic        last_of_run
);

    // The scanner classifies each character in the cycle it arrives and
    // hands every token it completes to the queue as one bundle. The output
    // stage drains that bundle a token per transaction, so a slow consumer
    // only stalls the scanner once the queue fills.

    bundle_t bundle;
    logic    bundle_valid;
    logic    accept;
    bundle_t head;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    token_t  cur;
    logic    cur_last;

    // Advance the scanner on every accepted character transaction
    assign accept = push && !q_full;
    assign full   = q_full;

    tel_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .character    (character),
        .text_end     (text_end),
        .accept       (accept),
        .bundle       (bundle),
        .bundle_valid (bundle_valid)
    );

    // Drop characters that complete nothing: only real bundles are queued
    tel_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && bundle_valid),
        .wr_data (bundle),
        .rd_en   (q_pop),
        .head    (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    tel_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (q_empty),
        .pop        (pop),
        .cur        (cur),
        .cur_last   (cur_last),
        .head_pop   (q_pop)
    );

    // Present the oldest waiting token
    assign empty       = q_empty;
    assign kind        = cur.kind;
    assign start_res   = cur.start;
    assign length      = cur.len;
    assign error_code  = cur.err;
    assign last_of_run = cur_last;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for template_expression_lexer
// Streams texts through the character queue and checks every token
// transaction against a cycle-free predictor held in a small scoreboard:
// a directed opening, random texts under three idling patterns and a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import tel_pkg::*;

    // Scanner modes and the first character of a pending operator
    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_IDENT, SCAN_INT, SCAN_STRING, SCAN_OPERATOR, SCAN_DISCARD
    } scan_mode_e;

    typedef enum logic [1:0] {OPF_NONE, OPF_LESS, OPF_GREQ, OPF_BANG} op_first_e;

    // Keyword being tracked while an identifier grows
    typedef enum logic [2:0] {KW_NONE, KW_OR, KW_AND, KW_TRUE, KW_FALSE} keyword_e;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [1:0]  err;
        logic        last_of_run;
    } lex_token_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the tokens of each accepted character and holds
    // them until the matching result transactions arrive.
    // ------------------------------------------------------------------------
    class token_scoreboard;
        lex_token_t  awaited_tokens[$];
        lex_token_t  step_tokens[$];
        int          mismatches;
        scan_mode_e  mode;
        int unsigned tok_start;
        int unsigned position;
        bit          double_quote;
        keyword_e    kw_word;
        int          kw_count;
        op_first_e   op_first;

        function new();
            mismatches = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            mode         = SCAN_IDLE;
            tok_start    = 0;
            position     = 0;
            double_quote = 1'b0;
            kw_word      = KW_NONE;
            kw_count     = 0;
            op_first     = OPF_NONE;
        endfunction

        task report_mismatch(input string what);
            $display("MISMATCH @%0t: %s", $time, what);
            mismatches++;
        endtask

        static function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        static function bit is_blank(logic [7:0] c);
            return c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
        endfunction

        static function string kw_spelling(keyword_e w);
            case (w)
                KW_OR:    return "or";
                KW_AND:   return "and";
                KW_TRUE:  return "true";
                KW_FALSE: return "false";
                default:  return "";
            endcase
        endfunction

        function void emit(logic [3:0] k, int unsigned s, int unsigned l, logic [1:0] e);
            lex_token_t t;
            if (step_tokens.size() >= MAX_RES)
                return;
            t.kind        = k;
            t.start       = s[15:0];
            t.len         = l[15:0];
            t.err         = e;
            t.last_of_run = 1'b0;
            step_tokens.push_back(t);
        endfunction

        function logic [3:0] ident_kind();
            string spelt;
            spelt = kw_spelling(kw_word);
            if (kw_word == KW_NONE || kw_count != spelt.len())
                return KIND_IDENT;
            if (kw_word == KW_OR || kw_word == KW_AND)
                return KIND_OPER;
            return KIND_BOOL;
        endfunction

        // Close any identifier, integer or single-character operator
        function void flush(int unsigned endpos);
            case (mode)
                SCAN_IDENT:    emit(ident_kind(), tok_start, endpos - tok_start, ERR_NONE);
                SCAN_INT:      emit(KIND_INT, tok_start, endpos - tok_start, ERR_NONE);
                SCAN_OPERATOR: emit(KIND_OPER, tok_start, 1, ERR_NONE);
                default: ;
            endcase
            mode     = SCAN_IDLE;
            op_first = OPF_NONE;
            kw_word  = KW_NONE;
            kw_count = 0;
        endfunction

        function void start_token(logic [7:0] c, int unsigned p);
            case (c)
                "|": emit(KIND_PIPE, p, 1, ERR_NONE);
                ":": emit(KIND_COLON, p, 1, ERR_NONE);
                ".": emit(KIND_DOT, p, 1, ERR_NONE);
                ",": emit(KIND_COMMA, p, 1, ERR_NONE);
                "[": emit(KIND_LBRACKET, p, 1, ERR_NONE);
                "]": emit(KIND_RBRACKET, p, 1, ERR_NONE);
                default:
                begin
                    if (is_blank(c))
                        return;
                    tok_start = p;
                    if (is_digit(c))
                        mode = SCAN_INT;
                    else if (c == "'" || c == "\"")
                    begin
                        mode         = SCAN_STRING;
                        double_quote = (c == "\"");
                    end
                    else if (is_letter(c) || c == "_")
                    begin
                        mode     = SCAN_IDENT;
                        kw_count = 1;
                        case (c)
                            "o":     kw_word = KW_OR;
                            "a":     kw_word = KW_AND;
                            "t":     kw_word = KW_TRUE;
                            "f":     kw_word = KW_FALSE;
                            default: kw_word = KW_NONE;
                        endcase
                    end
                    else if (c == "<" || c == ">" || c == "=" || c == "!")
                    begin
                        mode     = SCAN_OPERATOR;
                        op_first = (c == "<") ? OPF_LESS : (c == "!") ? OPF_BANG : OPF_GREQ;
                    end
                    else
                    begin
                        emit(KIND_END, p, 0, ERR_BAD_CHAR);
                        mode = SCAN_DISCARD;
                    end
                end
            endcase
        endfunction

        function void take_char(logic [7:0] c, int unsigned p);
            string spelt;
            case (mode)
                SCAN_IDENT:
                begin
                    if (is_letter(c) || is_digit(c) || c == "_")
                    begin
                        spelt = kw_spelling(kw_word);
                        if (kw_word != KW_NONE && kw_count < spelt.len() &&
                            c == spelt[kw_count])
                            kw_count++;
                        else
                            kw_word = KW_NONE;
                        return;
                    end
                    flush(p);
                end
                SCAN_INT:
                begin
                    if (is_digit(c))
                        return;
                    flush(p);
                end
                SCAN_STRING:
                begin
                    if (c == (double_quote ? 8'h22 : 8'h27))
                    begin
                        emit(KIND_STRING, tok_start, p - tok_start + 1, ERR_NONE);
                        mode = SCAN_IDLE;
                    end
                    return;
                end
                SCAN_OPERATOR:
                begin
                    if (c == "=" || (op_first == OPF_LESS && c == ">"))
                    begin
                        emit(KIND_OPER, tok_start, 2, ERR_NONE);
                        mode     = SCAN_IDLE;
                        op_first = OPF_NONE;
                        return;
                    end
                    flush(p);
                end
                SCAN_DISCARD: return;
                default: mode = SCAN_IDLE;
            endcase
            start_token(c, p);
        endfunction

        // Note one accepted character transaction and queue its tokens
        function void note_input(logic [7:0] c, logic is_last);
            int unsigned p;
            p = position;
            step_tokens.delete();
            if (mode != SCAN_DISCARD)
            begin
                if (p >= MAX_TEXT_LEN)
                begin
                    if (mode == SCAN_STRING)
                        mode = SCAN_IDLE;
                    flush(p);
                    emit(KIND_END, p, 0, ERR_TOO_LONG);
                    mode = SCAN_DISCARD;
                end
                else
                    take_char(c, p);
            end
            if (p < MAX_TEXT_LEN)
                position = p + 1;
            if (is_last)
            begin
                if (mode == SCAN_STRING)
                begin
                    emit(KIND_END, tok_start, 0, ERR_UNTERM);
                    mode = SCAN_IDLE;
                end
                flush(position);
                emit(KIND_END, position, 0, ERR_NONE);
                clear_scan();
            end
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
            foreach (step_tokens[i])
                awaited_tokens.push_back(step_tokens[i]);
        endfunction

        // Compare one result transaction with the oldest awaited token
        task check_result(logic [3:0] k, logic [15:0] s, logic [15:0] l,
                          logic [1:0] e, logic lr);
            lex_token_t want;
            if (awaited_tokens.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d start %0d", k, s));
                return;
            end
            want = awaited_tokens.pop_front();
            if (k !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", k, want.kind));
            if (s !== want.start)
                report_mismatch($sformatf("start_res %0d, expected %0d", s, want.start));
            if (l !== want.len)
                report_mismatch($sformatf("length %0d, expected %0d", l, want.len));
            if (e !== want.err)
                report_mismatch($sformatf("error_code %0d, expected %0d", e, want.err));
            if (lr !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                          lr, want.last_of_run));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  character = 8'h00;
    logic        text_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  kind;
    logic [15:0] start_res;
    logic [15:0] length;
    logic [1:0]  error_code;
    logic        last_of_run;

    template_expression_lexer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .character   (character),
        .text_end    (text_end),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .start_res   (start_res),
        .length      (length),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    token_scoreboard tokens = new();

    // Idling odds in percent, and the receiver hold-off still to serve
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_left = 0;

    // Text being assembled for the sender
    logic [7:0] text_buf[$];

    localparam string IDENT_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam int IDENT_FIRST_LAST = 52;  // letters and underscore only

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Generous overall limit: well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("** template_expression_lexer: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: check each result transaction taken at this edge, then decide
    // whether to pop on the next one. A requested hold-off is served here,
    // one cycle at a time, so that the block fills and stalls its input.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
                tokens.check_result(kind, start_res, length, error_code, last_of_run);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one character and hold it until the block takes it
    task automatic send_char(input logic [7:0] c, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        character <= c;
        text_end  <= is_last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tokens.note_input(c, is_last);
    endtask

    // Send the assembled text, marking its last character
    task automatic send_text();
        foreach (text_buf[i])
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    function automatic void append_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    task automatic send_literal(input string s);
        text_buf.delete();
        append_str(s);
        send_text();
    endtask

    // Append one random fragment; a clean fragment never opens a string nor
    // carries a bad byte
    function automatic void add_fragment(input bit clean);
        string      keywords[10] = '{"or", "and", "true", "false", "orb",
                                     "an", "truex", "False", "o", "t"};
        string      operators[9] = '{"<", "<=", "<>", ">", ">=", "=", "==", "!", "!="};
        string      punct = "|:.,[]";
        logic [7:0] blanks[5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
        logic [7:0] quote;
        logic [7:0] b;
        int         pick;
        int         n;
        pick = $urandom_range(0, 19);
        if (clean && (pick == 7 || pick == 19))
            pick = 12;
        case (pick)
            0, 1:
                append_str(keywords[$urandom_range(0, 9)]);
            2, 3, 4:
            begin
                n = $urandom_range(0, 5);
                text_buf.push_back(IDENT_CHARS[$urandom_range(0, IDENT_FIRST_LAST)]);
                repeat (n)
                    text_buf.push_back(IDENT_CHARS[$urandom_range(0, IDENT_CHARS.len() - 1)]);
            end
            5, 6:
                repeat ($urandom_range(1, 5))
                    text_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
            7:
            begin
                // quoted string, any byte but the quote inside, now and then left open
                quote = $urandom_range(0, 1) ? 8'h22 : 8'h27;
                text_buf.push_back(quote);
                repeat ($urandom_range(0, 5))
                begin
                    b = 8'($urandom_range(0, 255));
                    text_buf.push_back(b == quote ? 8'h41 : b);
                end
                if ($urandom_range(0, 7) != 0)
                    text_buf.push_back(quote);
            end
            8, 9, 10:
                append_str(operators[$urandom_range(0, 8)]);
            11:
                text_buf.push_back(punct[$urandom_range(0, 5)]);
            12, 13:
                repeat ($urandom_range(1, 3))
                    text_buf.push_back(blanks[$urandom_range(0, 4)]);
            19:
                text_buf.push_back(8'($urandom_range(0, 255)));
            default:
                text_buf.push_back(8'h20);
        endcase
    endfunction

    // Random texts until the given number of characters has gone
    task automatic send_random_texts(input int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            text_buf.delete();
            repeat ($urandom_range(1, 7))
                add_fragment(1'b0);
            send_text();
            sent += text_buf.size();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int spin;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: every punctuation mark, the operators <>, <=
        // and >=, a closed string holding a newline and a high byte, an
        // open string at text end, adjacent integer and identifier, a
        // pending operator closed by a bad character, a lone zero byte
        send_literal("|:.,[]<><=");
        text_buf.delete();
        append_str("'a\n");
        text_buf.push_back(8'h80);
        append_str("'\"x");
        send_text();
        send_literal("12ab!");
        send_literal("<\n");
        text_buf.delete();
        text_buf.push_back(8'h00);
        send_text();
        send_literal("true>=x");

        // Sender idles lightly, receiver heavily
        send_idle_pct = 11;
        recv_idle_pct = 55;
        send_random_texts(130);

        // Then the other way round
        send_idle_pct = 55;
        recv_idle_pct = 11;
        send_random_texts(130);

        // No idling; first hold the receiver off while characters keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_left = 80;
        send_random_texts(40);
        send_random_texts(100);

        push <= 1'b0;

        // Drain: wait for every awaited token, then a few spare cycles
        spin = 0;
        while (tokens.awaited_tokens.size() != 0 && spin < 5000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (8)
            @(posedge clk);
        if (tokens.awaited_tokens.size() != 0)
            tokens.report_mismatch($sformatf("%0d tokens never arrived",
                                             tokens.awaited_tokens.size()));

        if (tokens.mismatches == 0)
            $display("** template_expression_lexer: PASSED **");
        else
            $display("** template_expression_lexer: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
design/tel_pkg.sv
design/tel_front.sv
design/tel_queue.sv
design/tel_back.sv
design/template_expression_lexer.sv
tb/testbench.sv
